// ----- rtl/core/bia_pkg.sv -----
`timescale 1ns / 1ps

package bia_pkg;

	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = 32;
	localparam int TOTAL_IDS = WORD_BITS * NUM_WORDS;

	localparam int ID_W   = 10;
	localparam int MARK_W = 11;
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int WORD_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	// wide enough for the limit, a word base and the rounded-up word count
	localparam int CNT_RAW = $clog2(TOTAL_IDS + WORD_BITS);
	localparam int CNT_W   = (CNT_RAW > MARK_W) ? CNT_RAW : MARK_W;

	localparam logic [MARK_W-1:0] LIMIT_RESET = MARK_W'(1024);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] STATUS_ALLOC = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_FREED = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_UP,
		OP_FREE,
		OP_DOWN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic fin_up;
		logic fin_free;
		logic fin_down;
	} dp_stat_t;

endpackage

// ----- rtl/core/bitmap_id_allocator.sv -----
`timescale 1ns / 1ps

// Bitmap identifier allocator: allocate returns the lowest free identifier
// below id_limit (status 1 if none), free clears one identifier, and every
// result carries the high-water mark (one plus the highest identifier in
// use). The bitmap is read one word per cycle. An allocate loads the request
// and then examines one word after another, at least one word and at most
// ceil(min(id_limit, 1024) / 32). A free loads the request and clears the bit,
// and, when the top identifier is released, then scans the lower words
// until a set bit is found or word 0 is reached. A new request is taken while the last
// result still waits in the output register; a request stalls only at its
// final step if that result has not been taken yet. Write id_limit only
// while no request is in flight.
module bitmap_id_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic [bia_pkg::ID_W-1:0]   free_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bia_pkg::ID_W-1:0]   granted_id,
	output logic [1:0]                 status,
	output logic [bia_pkg::MARK_W-1:0] high_water,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bia_pkg::MARK_W-1:0] cfg_data
);
	import bia_pkg::*;

	logic [MARK_W-1:0] id_limit_q;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			id_limit_q <= cfg_data;
		end
	end

	bia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bia_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.free_index (free_index),
		.id_limit   (id_limit_q),
		.stat       (stat),
		.granted_id (granted_id),
		.status     (status),
		.high_water (high_water)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_ALLOC || status == STATUS_FULL ||
			status == STATUS_FREED))
		else $error("invalid result status");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CNT_W'(high_water) <= CNT_W'(TOTAL_IDS)))
		else $error("high-water mark beyond bitmap");

	a_zero_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STATUS_ALLOC) |-> (granted_id == '0))
		else $error("nonzero id on full or free result");

	a_mark_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_ALLOC) |->
			(high_water > MARK_W'(granted_id)))
		else $error("mark does not cover granted id");

endmodule

// ----- rtl/core/bia_datapath.sv -----
`timescale 1ns / 1ps

module bia_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bia_pkg::dp_cmd_t          cmd,
	input  logic                      func,
	input  logic [bia_pkg::ID_W-1:0]  free_index,
	input  logic [bia_pkg::MARK_W-1:0] id_limit,
	output bia_pkg::dp_stat_t         stat,
	output logic [bia_pkg::ID_W-1:0]  granted_id,
	output logic [1:0]                status,
	output logic [bia_pkg::MARK_W-1:0] high_water
);
	import bia_pkg::*;

	logic [WORD_BITS-1:0] bitmap_q [NUM_WORDS];
	logic [WORD_W-1:0]    ptr_q;
	logic [ID_W-1:0]      idx_q;
	logic [MARK_W-1:0]    mark_q;
	logic [ID_W-1:0]      granted_q;
	logic [1:0]           status_q;
	logic [MARK_W-1:0]    hw_q;

	logic [CNT_W-1:0]     lim;
	logic [CNT_W-1:0]     nw;
	logic [CNT_W-1:0]     base;
	logic [CNT_W-1:0]     rem;
	logic [WORD_BITS-1:0] word_rd;
	logic [WORD_BITS-1:0] lim_mask;
	logic [WORD_BITS-1:0] free_vec;
	logic [BIT_W-1:0]     lsb;
	logic                 up_hit;
	logic                 up_last;
	logic [CNT_W-1:0]     alloc_id1;

	logic [CNT_W-1:0]     idx_word;
	logic                 in_map;
	logic [WORD_BITS-1:0] bit_sel;
	logic                 rescan;
	logic [WORD_BITS-1:0] cand;
	logic [BIT_W-1:0]     msb;
	logic                 dn_hit;
	logic                 ptr_zero;
	logic [MARK_W-1:0]    dn_mark;

	logic [CNT_W-1:0]     new_word;
	logic                 new_in_map;
	logic [WORD_W-1:0]    new_ptr;

	assign lim = (CNT_W'(id_limit) < CNT_W'(TOTAL_IDS)) ? CNT_W'(id_limit) : CNT_W'(TOTAL_IDS);
	assign nw  = (lim + CNT_W'(WORD_BITS - 1)) >> BIT_W;
	assign base = CNT_W'(ptr_q) << BIT_W;
	assign word_rd = bitmap_q[ptr_q];
	assign rem = (lim > base) ? (lim - base) : '0;
	// identifiers in this word that sit below the limit
	assign lim_mask = (rem >= CNT_W'(WORD_BITS)) ? '1 : ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
	assign free_vec = ~word_rd & lim_mask;

	always_comb begin
		lsb = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				lsb = BIT_W'(i);
			end
		end
	end

	assign up_hit    = |free_vec;
	assign up_last   = (CNT_W'(ptr_q) + CNT_W'(1)) >= nw;
	assign alloc_id1 = base + CNT_W'(lsb) + CNT_W'(1);

	assign idx_word = CNT_W'(idx_q) >> BIT_W;
	assign in_map   = idx_word < CNT_W'(NUM_WORDS);
	assign bit_sel  = WORD_BITS'(1) << idx_q[BIT_W-1:0];
	assign rescan   = CNT_W'(mark_q) == (CNT_W'(idx_q) + CNT_W'(1));

	// first word of a downward scan only looks below the freed bit
	always_comb begin
		if (in_map && (CNT_W'(ptr_q) == idx_word)) begin
			cand = word_rd & (bit_sel - WORD_BITS'(1));
		end else begin
			cand = word_rd;
		end
	end

	always_comb begin
		msb = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (cand[i]) begin
				msb = BIT_W'(i);
			end
		end
	end

	assign dn_hit   = |cand;
	assign ptr_zero = ptr_q == '0;
	assign dn_mark  = dn_hit ? MARK_W'(base + CNT_W'(msb) + CNT_W'(1)) : '0;

	assign stat.fin_up   = up_hit || up_last;
	assign stat.fin_free = !rescan || dn_hit || ptr_zero;
	assign stat.fin_down = dn_hit || ptr_zero;

	assign new_word   = CNT_W'(free_index) >> BIT_W;
	assign new_in_map = new_word < CNT_W'(NUM_WORDS);
	assign new_ptr    = new_in_map ? new_word[WORD_W-1:0] : WORD_W'(NUM_WORDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				bitmap_q[i] <= '0;
			end
			ptr_q     <= '0;
			idx_q     <= '0;
			mark_q    <= '0;
			granted_q <= '0;
			status_q  <= STATUS_ALLOC;
			hw_q      <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					idx_q <= free_index;
					ptr_q <= (func == FUNC_FREE) ? new_ptr : '0;
				end
				OP_UP: begin
					if (up_hit) begin
						bitmap_q[ptr_q] <= word_rd | (WORD_BITS'(1) << lsb);
						granted_q       <= ID_W'(alloc_id1 - CNT_W'(1));
						status_q        <= STATUS_ALLOC;
						if (alloc_id1 > CNT_W'(mark_q)) begin
							mark_q <= MARK_W'(alloc_id1);
							hw_q   <= MARK_W'(alloc_id1);
						end else begin
							hw_q <= mark_q;
						end
					end else if (up_last) begin
						granted_q <= '0;
						status_q  <= STATUS_FULL;
						hw_q      <= mark_q;
					end else begin
						ptr_q <= ptr_q + WORD_W'(1);
					end
				end
				OP_FREE: begin
					if (in_map) begin
						bitmap_q[ptr_q] <= word_rd & ~bit_sel;
					end
					if (!rescan) begin
						granted_q <= '0;
						status_q  <= STATUS_FREED;
						hw_q      <= mark_q;
					end else if (dn_hit || ptr_zero) begin
						mark_q    <= dn_mark;
						granted_q <= '0;
						status_q  <= STATUS_FREED;
						hw_q      <= dn_mark;
					end else begin
						ptr_q <= ptr_q - WORD_W'(1);
					end
				end
				OP_DOWN: begin
					if (dn_hit || ptr_zero) begin
						mark_q    <= dn_mark;
						granted_q <= '0;
						status_q  <= STATUS_FREED;
						hw_q      <= dn_mark;
					end else begin
						ptr_q <= ptr_q - WORD_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign granted_id = granted_q;
	assign status     = status_q;
	assign high_water = hw_q;

endmodule

// ----- rtl/core/bia_ctrl.sv -----
`timescale 1ns / 1ps

module bia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	output logic              out_valid,
	input  logic              out_ready,
	input  bia_pkg::dp_stat_t stat,
	output bia_pkg::dp_cmd_t  cmd
);
	import bia_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UP,
		S_FREE,
		S_DOWN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_fin;
	logic   fin;

	// a finishing step may only run when the output register is free
	assign can_fin = !out_valid_q || out_ready;

	always_comb begin
		cmd.op  = OP_NONE;
		state_d = state_q;
		fin     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = (func == FUNC_FREE) ? S_FREE : S_UP;
				end
			end
			S_UP: begin
				if (!stat.fin_up) begin
					cmd.op = OP_UP;
				end else if (can_fin) begin
					cmd.op  = OP_UP;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				if (!stat.fin_free) begin
					cmd.op  = OP_FREE;
					state_d = S_DOWN;
				end else if (can_fin) begin
					cmd.op  = OP_FREE;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DOWN: begin
				if (!stat.fin_down) begin
					cmd.op = OP_DOWN;
				end else if (can_fin) begin
					cmd.op  = OP_DOWN;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule
